@@ src/sfu_pkg.sv @@
// Package: widths, codes and cell state types for the steering force unit.
`timescale 1ns / 1ps
`default_nettype none
package sfu_pkg;

   localparam int FRAC_BITS = 16;
   localparam int POS_W     = 32;
   localparam int D_W       = POS_W + 1;
   localparam int SQ_W      = 2 * D_W;
   localparam int RAD_W     = SQ_W + 2;
   localparam int ROOT_W    = RAD_W / 2;
   localparam int REM_W     = ROOT_W + 4;
   localparam int LIM_W     = 31;
   localparam int NUM_W     = 64;
   localparam int QUO_W     = 33;
   localparam int HI_W      = NUM_W - QUO_W;
   localparam int DREM_W    = ROOT_W + 1;
   localparam int CSR_IDX_W = 8;
   localparam int SQRT_CELLS = ROOT_W;
   localparam int DIV_CELLS  = QUO_W;

   typedef enum logic [1:0] {
      ACT_SEEK   = 2'd0,
      ACT_FLEE   = 2'd1,
      ACT_ARRIVE = 2'd2
   } action_type;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FORCE   = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AREA_RADIUS = 8'd1;
   localparam logic [LIM_W-1:0]     LIMIT_RESET     = 31'd65536;

   typedef struct packed {
      logic [RAD_W-1:0]  s;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
   } sqrt_type;

   typedef struct packed {
      logic [QUO_W-1:0]  num;
      logic [DREM_W-1:0] rem;
      logic [QUO_W-1:0]  quo;
      logic [ROOT_W-1:0] dvsr;
   } div_type;

   typedef struct packed {
      logic [1:0]            action;
      logic [2:0][D_W-1:0]   mag;
      logic [2:0]            neg;
      logic [2:0]            ovf;
      logic                  zero;
      logic                  deg;
   } side_type;

endpackage
`default_nettype wire

@@ src/sfu_req_if.sv @@
// Request channel: action plus target and agent positions.
`timescale 1ns / 1ps
`default_nettype none
interface sfu_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        action;
   logic signed [31:0] target_x;
   logic signed [31:0] target_y;
   logic signed [31:0] target_z;
   logic signed [31:0] agent_x;
   logic signed [31:0] agent_y;
   logic signed [31:0] agent_z;

   modport source (output valid, action, target_x, target_y, target_z,
                   agent_x, agent_y, agent_z, input ready);
   modport sink (input valid, action, target_x, target_y, target_z,
                 agent_x, agent_y, agent_z, output ready);
endinterface
`default_nettype wire

@@ src/sfu_rsp_if.sv @@
// Response channel: steering force and degenerate flag.
`timescale 1ns / 1ps
`default_nettype none
interface sfu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] force_x;
   logic signed [31:0] force_y;
   logic signed [31:0] force_z;
   logic               degenerate;

   modport source (output valid, force_x, force_y, force_z, degenerate, input ready);
   modport sink (input valid, force_x, force_y, force_z, degenerate, output ready);
endinterface
`default_nettype wire

@@ src/steering_force_unit_top.sv @@
// Top level: seek / flee / arrive steering force pipeline.
//
//   channel  | dir | handshake         | contents
//   req_chan | in  | valid/ready       | action, target xyz, agent xyz
//   rsp_chan | out | valid/ready       | force xyz, degenerate
//   csr_*    | in  | csr_we, no stall  | max_force (0), area_radius (1)
//
// One request per cycle while the skid register is empty; the pipe has 3 front stages, a 34-cell root
// chain, 2 scaling stages, a 33-cell divider chain per component and 1 output stage.
// Reset is synchronous, clears valids and loads both limit registers with 1.0.
// A response held by the sink goes to a skid register; the pipe stalls only
// while that register is full.
`timescale 1ns / 1ps
`default_nettype none
module steering_force_unit_top (
   input  logic                           clock,
   input  logic                           reset,
   sfu_req_if.sink                        req_chan,
   sfu_rsp_if.source                      rsp_chan,
   input  logic                           csr_we,
   input  logic [sfu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfu_pkg::LIM_W-1:0]      csr_wdata
);
   import sfu_pkg::*;

   typedef struct packed {
      logic [POS_W-1:0] fx;
      logic [POS_W-1:0] fy;
      logic [POS_W-1:0] fz;
      logic             deg;
   } out_type;

   logic [LIM_W-1:0] max_force_ff, area_radius_ff;
   logic             en;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_force_ff   <= LIMIT_RESET;
         area_radius_ff <= LIMIT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_FORCE:   max_force_ff   <= csr_wdata;
            CSR_AREA_RADIUS: area_radius_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // front: difference, squares, sum
   logic [2:0][POS_W-1:0] tgt, agt;
   side_type              s0_sd_in, s0_sd_ff, s1_sd_ff;
   logic                  s0_v_ff, s1_v_ff;
   logic [2:0][SQ_W-1:0]  sq_ff;

   assign tgt = {req_chan.target_z, req_chan.target_y, req_chan.target_x};
   assign agt = {req_chan.agent_z, req_chan.agent_y, req_chan.agent_x};

   always_comb begin
      logic [D_W-1:0] diff;
      s0_sd_in        = '0;
      s0_sd_in.action = req_chan.action;
      for (int i = 0; i < 3; i++) begin
         if (req_chan.action == ACT_FLEE)
            diff = {agt[i][POS_W-1], agt[i]} - {tgt[i][POS_W-1], tgt[i]};
         else
            diff = {tgt[i][POS_W-1], tgt[i]} - {agt[i][POS_W-1], agt[i]};
         s0_sd_in.neg[i] = diff[D_W-1];
         s0_sd_in.mag[i] = diff[D_W-1] ? (~diff + 1'b1) : diff;
      end
   end

   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
      end else if (en) begin
         s0_v_ff <= req_chan.valid;
         s1_v_ff <= s0_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_sd_ff <= s0_sd_in;
         s1_sd_ff <= s0_sd_ff;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= s0_sd_ff.mag[i] * s0_sd_ff.mag[i];
         end
      end
   end

   // root chain
   sqrt_type sq_st [0:SQRT_CELLS];
   side_type sd_sq [0:SQRT_CELLS];
   logic     v_sq  [0:SQRT_CELLS];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_sq[0] <= 1'b0;
      end else if (en) begin
         v_sq[0] <= s1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq_st[0].s    <= {2'b00, sq_ff[0]} + {2'b00, sq_ff[1]} + {2'b00, sq_ff[2]};
         sq_st[0].rem  <= '0;
         sq_st[0].root <= '0;
         sd_sq[0]      <= s1_sd_ff;
      end
   end

   for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_sqrt
      sfu_sqrt_cell u_cell (
         .clock   (clock),
         .en      (en),
         .st_prev (sq_st[k]),
         .st_ff   (sq_st[k+1])
      );
      always_ff @(posedge clock) begin
         if (reset) begin
            v_sq[k+1] <= 1'b0;
         end else if (en) begin
            v_sq[k+1] <= v_sq[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sd_sq[k+1] <= sd_sq[k];
         end
      end
   end

   // scaling: pick numerator and divisor
   logic [ROOT_W-1:0]      m, lim;
   logic                   near, act_ok, deg;
   side_type               m_sd_in, m_sd_ff;
   logic [2:0][NUM_W-1:0]  m_num_in, m_num_ff;
   logic [ROOT_W-1:0]      m_dvsr_ff;
   logic                   m_v_ff;

   assign m      = sq_st[SQRT_CELLS].root;
   assign lim    = {{(ROOT_W-LIM_W){1'b0}}, max_force_ff};
   assign act_ok = (sd_sq[SQRT_CELLS].action == ACT_SEEK) ||
                   (sd_sq[SQRT_CELLS].action == ACT_FLEE) ||
                   (sd_sq[SQRT_CELLS].action == ACT_ARRIVE);
   assign near   = (sd_sq[SQRT_CELLS].action == ACT_ARRIVE) &&
                   (m <= {{(ROOT_W-LIM_W){1'b0}}, area_radius_ff});
   assign deg    = act_ok && ((m == '0) || (lim == '0));

   always_comb begin
      m_sd_in      = sd_sq[SQRT_CELLS];
      m_sd_in.deg  = deg;
      m_sd_in.zero = deg || !act_ok;
      for (int i = 0; i < 3; i++) begin
         if (near)
            m_num_in[i] = {{(NUM_W-D_W-FRAC_BITS){1'b0}}, sd_sq[SQRT_CELLS].mag[i],
                           {FRAC_BITS{1'b0}}};
         else
            m_num_in[i] = sd_sq[SQRT_CELLS].mag[i] * max_force_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_v_ff <= 1'b0;
      end else if (en) begin
         m_v_ff <= v_sq[SQRT_CELLS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_sd_ff   <= m_sd_in;
         m_num_ff  <= m_num_in;
         m_dvsr_ff <= near ? lim : m;
      end
   end

   // divider chain, one lane per component
   div_type  dv_st [0:DIV_CELLS][0:2];
   side_type sd_dv [0:DIV_CELLS];
   logic     v_dv  [0:DIV_CELLS];
   side_type dv_sd_in;

   always_comb begin
      dv_sd_in = m_sd_ff;
      for (int i = 0; i < 3; i++) begin
         dv_sd_in.ovf[i] = {{(ROOT_W-HI_W){1'b0}}, m_num_ff[i][NUM_W-1:QUO_W]}
                           >= m_dvsr_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_dv[0] <= 1'b0;
      end else if (en) begin
         v_dv[0] <= m_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sd_dv[0] <= dv_sd_in;
         for (int i = 0; i < 3; i++) begin
            dv_st[0][i].num  <= m_num_ff[i][QUO_W-1:0];
            dv_st[0][i].rem  <= {{(DREM_W-HI_W){1'b0}}, m_num_ff[i][NUM_W-1:QUO_W]};
            dv_st[0][i].quo  <= '0;
            dv_st[0][i].dvsr <= m_dvsr_ff;
         end
      end
   end

   for (genvar k = 0; k < DIV_CELLS; k++) begin : g_div
      for (genvar j = 0; j < 3; j++) begin : g_lane
         sfu_div_cell u_cell (
            .clock   (clock),
            .en      (en),
            .st_prev (dv_st[k][j]),
            .st_ff   (dv_st[k+1][j])
         );
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_dv[k+1] <= 1'b0;
         end else if (en) begin
            v_dv[k+1] <= v_dv[k];
         end
      end
      always_ff @(posedge clock) begin
         if (en) begin
            sd_dv[k+1] <= sd_dv[k];
         end
      end
   end

   // saturate and present
   side_type              fin;
   logic [2:0][POS_W-1:0] f;
   out_type               out_in, out_ff, skid_ff;
   logic                  out_v_ff, skid_v_ff;

   assign fin = sd_dv[DIV_CELLS];

   always_comb begin
      logic [QUO_W-1:0] q;
      logic             big;
      for (int i = 0; i < 3; i++) begin
         q   = dv_st[DIV_CELLS][i].quo;
         big = fin.ovf[i] || q[QUO_W-1] || q[POS_W-1];
         if (fin.zero)
            f[i] = '0;
         else if (fin.neg[i])
            f[i] = big ? {1'b1, {(POS_W-1){1'b0}}} : (~q[POS_W-1:0] + 1'b1);
         else
            f[i] = big ? {1'b0, {(POS_W-1){1'b1}}} : q[POS_W-1:0];
      end
      out_in.fx  = f[0];
      out_in.fy  = f[1];
      out_in.fz  = f[2];
      out_in.deg = fin.deg;
   end

   assign en = !skid_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         if (en) begin
            out_v_ff <= v_dv[DIV_CELLS];
         end
         if (skid_v_ff) begin
            skid_v_ff <= !rsp_chan.ready;
         end else if (out_v_ff && !rsp_chan.ready) begin
            skid_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
         if (out_v_ff && !rsp_chan.ready) begin
            skid_ff <= out_ff;
         end
      end
   end

   assign rsp_chan.valid      = skid_v_ff || out_v_ff;
   assign rsp_chan.force_x    = skid_v_ff ? skid_ff.fx : out_ff.fx;
   assign rsp_chan.force_y    = skid_v_ff ? skid_ff.fy : out_ff.fy;
   assign rsp_chan.force_z    = skid_v_ff ? skid_ff.fz : out_ff.fz;
   assign rsp_chan.degenerate = skid_v_ff ? skid_ff.deg : out_ff.deg;

endmodule
`default_nettype wire

@@ src/sfu_sqrt_cell.sv @@
// Square root cell: resolves one root bit from two radicand bits.
`timescale 1ns / 1ps
`default_nettype none
module sfu_sqrt_cell (
   input  logic              clock,
   input  logic              en,
   input  sfu_pkg::sqrt_type st_prev,
   output sfu_pkg::sqrt_type st_ff
);
   import sfu_pkg::*;

   sqrt_type          st_in;
   logic [REM_W-1:0]  rem_sh;
   logic [REM_W-1:0]  trial;
   logic              ge;

   always_comb begin
      rem_sh = {st_prev.rem[REM_W-3:0], st_prev.s[RAD_W-1 -: 2]};
      trial  = {{(REM_W-ROOT_W-2){1'b0}}, st_prev.root, 2'b01};
      ge     = (rem_sh >= trial);
      st_in.s    = {st_prev.s[RAD_W-3:0], 2'b00};
      st_in.rem  = ge ? (rem_sh - trial) : rem_sh;
      st_in.root = {st_prev.root[ROOT_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end
endmodule
`default_nettype wire

@@ src/sfu_div_cell.sv @@
// Divider cell: one restoring quotient bit per cycle while en is high.
`timescale 1ns / 1ps
`default_nettype none
module sfu_div_cell (
   input  logic             clock,
   input  logic             en,
   input  sfu_pkg::div_type st_prev,
   output sfu_pkg::div_type st_ff
);
   import sfu_pkg::*;

   div_type           st_in;
   logic [DREM_W-1:0] rem_sh;
   logic [DREM_W-1:0] dv;
   logic              ge;

   always_comb begin
      rem_sh = {st_prev.rem[DREM_W-2:0], st_prev.num[QUO_W-1]};
      dv     = {1'b0, st_prev.dvsr};
      ge     = (rem_sh >= dv);
      st_in.num  = {st_prev.num[QUO_W-2:0], 1'b0};
      st_in.rem  = ge ? (rem_sh - dv) : rem_sh;
      st_in.quo  = {st_prev.quo[QUO_W-2:0], ge};
      st_in.dvsr = st_prev.dvsr;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st_ff <= st_in;
      end
   end
endmodule
`default_nettype wire

@@ tb/sfu_checker.sv @@
// Checker: predicts the steering force for each accepted request and compares responses.
`timescale 1ns / 1ps
`default_nettype none
module sfu_checker (
   input  logic                          clock,
   input  logic                          reset,
   sfu_req_if                            req,
   sfu_rsp_if                            rsp,
   input  logic                          csr_we,
   input  logic [sfu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [sfu_pkg::LIM_W-1:0]     csr_wdata,
   output int                            errors,
   output int                            pending
);
   import sfu_pkg::*;

   typedef struct packed {
      logic [2:0][31:0] f;
      logic             deg;
   } steer_force_type;

   logic [LIM_W-1:0] force_limit;
   logic [LIM_W-1:0] slow_radius;
   steer_force_type  expected_forces[$];

   function automatic steer_force_type compute_force(input logic [1:0] act,
                                                     input logic [2:0][31:0] tgt,
                                                     input logic [2:0][31:0] agt);
      logic signed [33:0] diff[3];
      logic [33:0]        mag[3];
      logic [67:0]        sum;
      logic [33:0]        root;
      logic [33:0]        cand;
      logic [63:0]        q;
      steer_force_type    r;
      r = '0;
      if (act != ACT_SEEK && act != ACT_FLEE && act != ACT_ARRIVE) return r;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         if (act == ACT_FLEE)
            diff[i] = {{2{agt[i][31]}}, agt[i]} - {{2{tgt[i][31]}}, tgt[i]};
         else
            diff[i] = {{2{tgt[i][31]}}, tgt[i]} - {{2{agt[i][31]}}, agt[i]};
         mag[i] = diff[i][33] ? -diff[i] : diff[i];
         sum = sum + 68'(mag[i]) * 68'(mag[i]);
      end
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         cand = root | (34'd1 << b);
         if (68'(cand) * 68'(cand) <= sum) root = cand;
      end
      if (root == 0 || force_limit == 0) begin
         r.deg = 1'b1;
         return r;
      end
      for (int i = 0; i < 3; i++) begin
         if (act == ACT_ARRIVE && 64'(root) <= 64'(slow_radius))
            q = (64'(mag[i]) << FRAC_BITS) / 64'(force_limit);
         else
            q = (64'(mag[i]) * 64'(force_limit)) / 64'(root);
         if (diff[i][33])
            r.f[i] = (q >= 64'h8000_0000) ? 32'h8000_0000 : -q[31:0];
         else
            r.f[i] = (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
      end
      return r;
   endfunction

   assign pending = expected_forces.size();

   always @(posedge clock) begin
      steer_force_type want, got;
      if (reset) begin
         errors = 0;
         force_limit <= LIMIT_RESET;
         slow_radius <= LIMIT_RESET;
         expected_forces.delete();
      end else begin
         if (csr_we && csr_index == CSR_MAX_FORCE) force_limit <= csr_wdata;
         if (csr_we && csr_index == CSR_AREA_RADIUS) slow_radius <= csr_wdata;
         if (req.valid && req.ready)
            expected_forces.push_back(compute_force(req.action,
               {req.target_z, req.target_y, req.target_x},
               {req.agent_z, req.agent_y, req.agent_x}));
         if (rsp.valid && rsp.ready) begin
            got.f = {rsp.force_z, rsp.force_y, rsp.force_x};
            got.deg = rsp.degenerate;
            if (expected_forces.size() == 0) begin
               $display("%0t: unexpected response %h", $time, got);
               errors++;
            end else begin
               want = expected_forces.pop_front();
               for (int i = 0; i < 3; i++)
                  if (got.f[i] !== want.f[i]) begin
                     $display("%0t: force[%0d] expected %h actual %h",
                              $time, i, want.f[i], got.f[i]);
                     errors++;
                  end
               if (got.deg !== want.deg) begin
                  $display("%0t: degenerate expected %b actual %b",
                           $time, want.deg, got.deg);
                  errors++;
               end
            end
         end
      end
   end
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench top: stimulus, configuration phases and verdict for the steering force unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import sfu_pkg::*;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BOGUS = 8'd2;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] POS_MIN = 32'h8000_0000;
   localparam logic [LIM_W-1:0] LIM_MAX = 31'h7FFF_FFFF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [LIM_W-1:0] csr_wdata = '0;
   int errors, pending;
   int send_idle = 0;
   int recv_stall = 0;

   sfu_req_if req_chan ();
   sfu_rsp_if rsp_chan ();

   steering_force_unit_top i_dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   sfu_checker i_checker (
      .clock(clock), .reset(reset), .req(req_chan), .rsp(rsp_chan),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .errors(errors), .pending(pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(negedge clock) rsp_chan.ready <= ($urandom_range(99) >= recv_stall);

   task automatic send_request(input logic [1:0] act, input logic [31:0] tx, ty, tz,
                               input logic [31:0] ax, ay, az);
      @(negedge clock);
      while ($urandom_range(99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.action <= act;
      req_chan.target_x <= tx;
      req_chan.target_y <= ty;
      req_chan.target_z <= tz;
      req_chan.agent_x <= ax;
      req_chan.agent_y <= ay;
      req_chan.agent_z <= az;
      while (!req_chan.ready) @(negedge clock);
      @(posedge clock);
   endtask

   task automatic drain;
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [LIM_W-1:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [31:0] rand_pos(input int kind);
      case (kind)
         0: rand_pos = $urandom;
         1: rand_pos = $urandom_range(32'h0004_0000) - 32'h0002_0000;
         2: rand_pos = $urandom_range(32'h0200_0000) - 32'h0100_0000;
         default: rand_pos = ($urandom_range(1)) ? POS_MAX : POS_MIN;
      endcase
   endfunction

   task automatic random_requests(input int count);
      logic [31:0] t[3];
      logic [31:0] a[3];
      int kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(3);
         for (int i = 0; i < 3; i++) begin
            t[i] = rand_pos(kind);
            a[i] = ($urandom_range(9) == 0) ? t[i] : rand_pos(kind);
         end
         if ($urandom_range(19) == 0) a = t;
         send_request(($urandom_range(15) == 0) ? ACT_UNUSED : 2'($urandom_range(2)),
                      t[0], t[1], t[2], a[0], a[1], a[2]);
         if (n == count / 2 && count > 20) drain();
      end
   endtask

   task automatic directed_requests;
      send_request(ACT_SEEK, 32'h0001_0000, 0, 0, 0, 0, 0);
      send_request(ACT_FLEE, 0, 32'h0003_0000, 0, 0, 0, 32'h0004_0000);
      send_request(ACT_ARRIVE, 32'h0000_8000, 0, 0, 0, 0, 0);
      send_request(ACT_ARRIVE, 32'h0010_0000, 32'h0010_0000, 0, 0, 0, 0);
      send_request(ACT_SEEK, 5, 5, 5, 5, 5, 5);
      send_request(ACT_ARRIVE, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN, POS_MIN);
      send_request(ACT_SEEK, POS_MAX, POS_MAX, POS_MAX, POS_MIN, POS_MIN, POS_MIN);
      send_request(ACT_FLEE, POS_MAX, POS_MIN, POS_MAX, POS_MIN, POS_MAX, POS_MIN);
      send_request(ACT_ARRIVE, POS_MIN, POS_MAX, 0, POS_MAX, POS_MIN, 0);
      send_request(ACT_ARRIVE, 1, 0, 0, 0, 0, 0);
      send_request(ACT_UNUSED, 32'h0001_0000, 7, 9, 0, 0, 0);
      send_request(ACT_FLEE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.action = ACT_SEEK;
      req_chan.target_x = '0;
      req_chan.target_y = '0;
      req_chan.target_z = '0;
      req_chan.agent_x = '0;
      req_chan.agent_y = '0;
      req_chan.agent_z = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 33;
      recv_stall = 52;
      directed_requests();
      drain();
      write_csr(CSR_MAX_FORCE, '0);
      directed_requests();
      drain();
      write_csr(CSR_MAX_FORCE, LIM_MAX);
      write_csr(CSR_AREA_RADIUS, LIM_MAX);
      directed_requests();
      random_requests(60);
      drain();
      write_csr(CSR_MAX_FORCE, 31'd1);
      write_csr(CSR_AREA_RADIUS, '0);
      write_csr(CSR_BOGUS, 31'h1234);
      send_idle = 52;
      recv_stall = 33;
      directed_requests();
      random_requests(60);
      drain();
      write_csr(CSR_MAX_FORCE, 31'h0002_0000);
      write_csr(CSR_AREA_RADIUS, 31'h0001_8000);
      random_requests(100);
      drain();
      send_idle = 0;
      recv_stall = 0;
      for (int p = 0; p < 3; p++) begin
         write_csr(CSR_MAX_FORCE, ($urandom_range(3) == 0) ? 31'($urandom)
                                  : 31'($urandom_range(32'h0004_0000)));
         write_csr(CSR_AREA_RADIUS, ($urandom_range(3) == 0) ? 31'($urandom)
                                    : 31'($urandom_range(32'h0040_0000)));
         random_requests(50);
         drain();
      end
      if (errors == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

   initial begin
      #2000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
`default_nettype wire

@@ sim.f @@
src/sfu_pkg.sv
src/sfu_req_if.sv
src/sfu_rsp_if.sv
src/sfu_sqrt_cell.sv
src/sfu_div_cell.sv
src/steering_force_unit_top.sv
tb/sfu_checker.sv
tb/tb_top.sv
